@@ hw/rtl/hrbp_pkg.sv @@
`default_nettype none
package hrbp_pkg;

   localparam int LengthBitsDefault = 32;

   // field codes on field_class
   localparam logic [2:0] FIELD_METHOD  = 3'd0;
   localparam logic [2:0] FIELD_TARGET  = 3'd1;
   localparam logic [2:0] FIELD_VERSION = 3'd2;
   localparam logic [2:0] FIELD_HNAME   = 3'd3;
   localparam logic [2:0] FIELD_HVALUE  = 3'd4;
   localparam logic [2:0] FIELD_BODY    = 3'd5;

   localparam logic [7:0] CHAR_SP    = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // length of the header name "content-length"
   localparam logic [3:0] NAME_LEN = 4'd14;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] out_byte;
      logic [2:0] field_class;
      logic       pair_done;
      logic       headers_done;
      logic       request_done;
      logic       last;
   } result_type;

   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } result_pair_type;

   function automatic logic [7:0] name_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = "c";
         4'd1:    c = "o";
         4'd2:    c = "n";
         4'd3:    c = "t";
         4'd4:    c = "e";
         4'd5:    c = "n";
         4'd6:    c = "t";
         4'd7:    c = "-";
         4'd8:    c = "l";
         4'd9:    c = "e";
         4'd10:   c = "n";
         4'd11:   c = "g";
         4'd12:   c = "t";
         4'd13:   c = "h";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hrbp_req_if.sv @@
`default_nettype none
interface hrbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/hrbp_rsp_if.sv @@
`default_nettype none
interface hrbp_rsp_if;
   logic       valid;
   logic       ready;
   logic       data_valid;
   logic [7:0] out_byte;
   logic [2:0] field_class;
   logic       pair_done;
   logic       headers_done;
   logic       request_done;
   logic       last;

   modport source (output valid, output data_valid, output out_byte, output field_class,
                   output pair_done, output headers_done, output request_done,
                   output last, input ready);
   modport sink (input valid, input data_valid, input out_byte, input field_class,
                 input pair_done, input headers_done, input request_done,
                 input last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/hrbp_core.sv @@
`default_nettype none
module hrbp_core
   import hrbp_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic [7:0]      in_byte,
   output      result_pair_type results
);

   typedef enum logic [3:0] {
      ST_METHOD  = 4'd0,
      ST_TARGET  = 4'd1,
      ST_VERSION = 4'd2,
      ST_LINE_CR = 4'd3,
      ST_HNAME   = 4'd4,
      ST_HVAL    = 4'd5,
      ST_VAL_CR  = 4'd6,
      ST_HEAD_CR = 4'd7,
      ST_BODY    = 4'd8
   } state_type;

   state_type              state_ff, state_in;
   logic                   value_started_ff, value_started_in;
   logic [3:0]             match_pos_ff, match_pos_in;
   logic                   mismatch_ff, mismatch_in;
   logic                   digits_open_ff, digits_open_in;
   logic [LENGTH_BITS-1:0] pending_ff, pending_in;
   logic                   length_seen_ff, length_seen_in;
   logic [LENGTH_BITS-1:0] body_length_ff, body_length_in;
   logic [LENGTH_BITS-1:0] body_count_ff, body_count_in;

   logic                   is_digit;
   logic [LENGTH_BITS+3:0] acc_wide;
   logic [LENGTH_BITS-1:0] acc;
   logic [LENGTH_BITS-1:0] count_next;
   result_type             r0, r1;
   logic                   two;

   function automatic result_type make_res(input logic v, input logic [7:0] b,
                                           input logic [2:0] c, input logic p,
                                           input logic h, input logic r);
      result_type x;
      x.data_valid   = v;
      x.out_byte     = v ? b : 8'h00;
      x.field_class  = c;
      x.pair_done    = p;
      x.headers_done = h;
      x.request_done = r;
      x.last         = 1'b0;
      return x;
   endfunction

   // decimal accumulate: pending * 10 + digit, saturating
   assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
   assign acc_wide = ({4'b0, pending_ff} << 3) + ({4'b0, pending_ff} << 1)
                     + {{LENGTH_BITS{1'b0}}, 4'(in_byte - CHAR_ZERO)};
   assign acc = (|acc_wide[LENGTH_BITS+3:LENGTH_BITS]) ? {LENGTH_BITS{1'b1}}
                                                      : acc_wide[LENGTH_BITS-1:0];
   assign count_next = body_count_ff + {{(LENGTH_BITS-1){1'b0}}, 1'b1};

   always_comb begin
      state_in         = state_ff;
      value_started_in = value_started_ff;
      match_pos_in     = match_pos_ff;
      mismatch_in      = mismatch_ff;
      digits_open_in   = digits_open_ff;
      pending_in       = pending_ff;
      length_seen_in   = length_seen_ff;
      body_length_in   = body_length_ff;
      body_count_in    = body_count_ff;
      two              = 1'b0;
      r0               = make_res(1'b0, 8'h00, FIELD_METHOD, 1'b0, 1'b0, 1'b0);
      r1               = make_res(1'b0, 8'h00, FIELD_METHOD, 1'b0, 1'b0, 1'b0);

      case (state_ff)
         ST_TARGET: begin
            if (in_byte == CHAR_SP) begin
               state_in = ST_VERSION;
               r0 = make_res(1'b0, 8'h00, FIELD_TARGET, 1'b0, 1'b0, 1'b0);
            end else begin
               r0 = make_res(1'b1, in_byte, FIELD_TARGET, 1'b0, 1'b0, 1'b0);
            end
         end
         ST_VERSION: begin
            if (in_byte == CHAR_CR) begin
               state_in = ST_LINE_CR;
               r0 = make_res(1'b0, 8'h00, FIELD_VERSION, 1'b0, 1'b0, 1'b0);
            end else begin
               r0 = make_res(1'b1, in_byte, FIELD_VERSION, 1'b0, 1'b0, 1'b0);
            end
         end
         ST_LINE_CR: begin
            if (in_byte == CHAR_LF) begin
               state_in = ST_HNAME;
               r0 = make_res(1'b0, 8'h00, FIELD_VERSION, 1'b0, 1'b0, 1'b0);
            end else if (in_byte == CHAR_CR) begin
               r0 = make_res(1'b1, CHAR_CR, FIELD_VERSION, 1'b0, 1'b0, 1'b0);
            end else begin
               // lone CR: pass it on ahead of this byte
               state_in = ST_VERSION;
               two = 1'b1;
               r0 = make_res(1'b1, CHAR_CR, FIELD_VERSION, 1'b0, 1'b0, 1'b0);
               r1 = make_res(1'b1, in_byte, FIELD_VERSION, 1'b0, 1'b0, 1'b0);
            end
         end
         ST_HNAME: begin
            if (in_byte == CHAR_COLON) begin
               state_in = ST_HVAL;
               r0 = make_res(1'b0, 8'h00, FIELD_HNAME, 1'b0, 1'b0, 1'b0);
            end else if (in_byte == CHAR_CR) begin
               state_in = ST_HEAD_CR;
               r0 = make_res(1'b0, 8'h00, FIELD_HNAME, 1'b0, 1'b0, 1'b0);
            end else begin
               if (match_pos_ff < NAME_LEN && in_byte == name_char(match_pos_ff)) begin
                  match_pos_in = match_pos_ff + 4'd1;
               end else begin
                  mismatch_in = 1'b1;
               end
               r0 = make_res(1'b1, in_byte, FIELD_HNAME, 1'b0, 1'b0, 1'b0);
            end
         end
         ST_HVAL: begin
            if (in_byte == CHAR_CR) begin
               state_in = ST_VAL_CR;
               r0 = make_res(1'b0, 8'h00, FIELD_HVALUE, 1'b0, 1'b0, 1'b0);
            end else if (in_byte == CHAR_SP && !value_started_ff) begin
               // drop leading spaces of the value
               r0 = make_res(1'b0, 8'h00, FIELD_HVALUE, 1'b0, 1'b0, 1'b0);
            end else begin
               value_started_in = 1'b1;
               if (digits_open_ff && is_digit) begin
                  pending_in = acc;
               end else begin
                  digits_open_in = 1'b0;
               end
               r0 = make_res(1'b1, in_byte, FIELD_HVALUE, 1'b0, 1'b0, 1'b0);
            end
         end
         ST_VAL_CR: begin
            if (in_byte == CHAR_LF) begin
               if (!mismatch_ff && match_pos_ff == NAME_LEN && !length_seen_ff) begin
                  length_seen_in = 1'b1;
                  body_length_in = pending_ff;
               end
               value_started_in = 1'b0;
               match_pos_in     = 4'd0;
               mismatch_in      = 1'b0;
               digits_open_in   = 1'b1;
               pending_in       = '0;
               state_in         = ST_HNAME;
               r0 = make_res(1'b0, 8'h00, FIELD_HVALUE, 1'b1, 1'b0, 1'b0);
            end else begin
               // the held CR is a value byte and closes the digit run
               value_started_in = 1'b1;
               digits_open_in   = 1'b0;
               r0 = make_res(1'b1, CHAR_CR, FIELD_HVALUE, 1'b0, 1'b0, 1'b0);
               if (in_byte != CHAR_CR) begin
                  state_in = ST_HVAL;
                  two = 1'b1;
                  r1 = make_res(1'b1, in_byte, FIELD_HVALUE, 1'b0, 1'b0, 1'b0);
               end
            end
         end
         ST_HEAD_CR: begin
            if (length_seen_ff && body_length_ff != '0) begin
               state_in      = ST_BODY;
               body_count_in = '0;
               r0 = make_res(1'b0, 8'h00, FIELD_HNAME, 1'b0, 1'b1, 1'b0);
            end else begin
               state_in         = ST_METHOD;
               value_started_in = 1'b0;
               match_pos_in     = 4'd0;
               mismatch_in      = 1'b0;
               digits_open_in   = 1'b1;
               pending_in       = '0;
               length_seen_in   = 1'b0;
               body_length_in   = '0;
               body_count_in    = '0;
               r0 = make_res(1'b0, 8'h00, FIELD_HNAME, 1'b0, 1'b1, 1'b1);
            end
         end
         ST_BODY: begin
            if (count_next >= body_length_ff) begin
               state_in         = ST_METHOD;
               value_started_in = 1'b0;
               match_pos_in     = 4'd0;
               mismatch_in      = 1'b0;
               digits_open_in   = 1'b1;
               pending_in       = '0;
               length_seen_in   = 1'b0;
               body_length_in   = '0;
               body_count_in    = '0;
               r0 = make_res(1'b1, in_byte, FIELD_BODY, 1'b0, 1'b0, 1'b1);
            end else begin
               body_count_in = count_next;
               r0 = make_res(1'b1, in_byte, FIELD_BODY, 1'b0, 1'b0, 1'b0);
            end
         end
         default: begin
            if (in_byte == CHAR_SP) begin
               state_in = ST_TARGET;
               r0 = make_res(1'b0, 8'h00, FIELD_METHOD, 1'b0, 1'b0, 1'b0);
            end else begin
               state_in = ST_METHOD;
               r0 = make_res(1'b1, in_byte, FIELD_METHOD, 1'b0, 1'b0, 1'b0);
            end
         end
      endcase

      r0.last = !two;
      r1.last = two;
   end

   assign results.two    = two;
   assign results.first  = r0;
   assign results.second = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_METHOD;
         value_started_ff <= 1'b0;
         match_pos_ff     <= 4'd0;
         mismatch_ff      <= 1'b0;
         digits_open_ff   <= 1'b1;
         pending_ff       <= '0;
         length_seen_ff   <= 1'b0;
         body_length_ff   <= '0;
         body_count_ff    <= '0;
      end else if (advance) begin
         state_ff         <= state_in;
         value_started_ff <= value_started_in;
         match_pos_ff     <= match_pos_in;
         mismatch_ff      <= mismatch_in;
         digits_open_ff   <= digits_open_in;
         pending_ff       <= pending_in;
         length_seen_ff   <= length_seen_in;
         body_length_ff   <= body_length_in;
         body_count_ff    <= body_count_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/hrbp_fifo.sv @@
`default_nettype none
module hrbp_fifo
   import hrbp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire result_pair_type pair,
   input  wire logic            pop,
   output      result_type      head,
   output      logic            not_empty,
   output      logic            room_for_two
);

   localparam int Depth = 4;
   localparam int PtrBits = $clog2(Depth);

   result_type         mem_ff [Depth];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]   count_ff, count_in;
   logic [PtrBits:0]   n_push;

   assign n_push = push ? (pair.two ? (PtrBits+1)'(2) : (PtrBits+1)'(1)) : '0;
   assign wr_ptr_in = wr_ptr_ff + n_push[PtrBits-1:0];
   assign rd_ptr_in = rd_ptr_ff + (PtrBits)'(pop);
   assign count_in = count_ff + n_push - (PtrBits+1)'(pop);

   assign head = mem_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign room_for_two = count_ff <= (PtrBits+1)'(Depth - 2);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= pair.first;
         if (pair.two) begin
            mem_ff[wr_ptr_ff + (PtrBits)'(1)] <= pair.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/http_request_byte_parser_top.sv @@
`default_nettype none
// HTTP request byte parser.
// req carries the raw request stream, one byte per word (in_byte). rsp carries
// one tagged word per field byte or delimiter: data_valid, out_byte,
// field_class, pair_done, headers_done, request_done and last. Every request
// byte gives one rsp word, except a lone CR inside the request line or a
// header value followed by another byte, which gives two (the CR, then the byte).
// The accepted byte is held in the one-byte input register; the parser reads it
// there, and its rsp words are written into the result queue, from which rsp
// offers them. Throughput: one byte per cycle while the queue has room; the
// parser advances once per cycle unless stalled and the rsp side drains one word
// per cycle while rsp.ready is high, so a lone-CR byte costs one extra rsp word.
// A 4-word result queue sits between the parser and rsp; the parser stalls
// when fewer than two slots are free and req.ready drops once the one-byte
// input register is also occupied. A stalled receiver loses nothing.
// Synchronous reset returns the parser to the method state with no body length
// and empties the input register and the result queue.
module http_request_byte_parser_top
   import hrbp_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input wire logic  clock,
   input wire logic  reset,
   hrbp_req_if.sink  req,
   hrbp_rsp_if.source rsp
);

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            advance;
   logic            room_for_two;
   logic            not_empty;
   result_pair_type pair;
   result_type      head;

   assign advance = in_valid_ff && room_for_two;
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.in_byte;
      end
   end

   hrbp_core #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte_ff),
      .results (pair)
   );

   hrbp_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (advance),
      .pair         (pair),
      .pop          (rsp.valid && rsp.ready),
      .head         (head),
      .not_empty    (not_empty),
      .room_for_two (room_for_two)
   );

   assign rsp.valid        = not_empty;
   assign rsp.data_valid   = head.data_valid;
   assign rsp.out_byte     = head.out_byte;
   assign rsp.field_class  = head.field_class;
   assign rsp.pair_done    = head.pair_done;
   assign rsp.headers_done = head.headers_done;
   assign rsp.request_done = head.request_done;
   assign rsp.last         = head.last;

endmodule
`default_nettype wire
